[sv/bchd_pkg.sv]
`timescale 1ns / 1ps

package bchd_pkg;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_SINGLE = 3'd1,
      EV_DOUBLE = 3'd2,
      EV_TRIPLE = 3'd3,
      EV_HOLD   = 3'd4
   } event_type;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_STEP   = 1'b1;

   localparam logic [1:0] CSR_ACTIVE_LOW  = 2'd0;
   localparam logic [1:0] CSR_HOLD_TARGET = 2'd1;
   localparam logic [1:0] CSR_MIN_PRESS   = 2'd2;
   localparam logic [1:0] CSR_CLICK_GAP   = 2'd3;

   localparam logic [7:0] HIST_ALL_PRESSED  = 8'hFF;
   localparam logic [7:0] HIST_ALL_RELEASED = 8'h00;
   localparam logic [2:0] CLICK_MAX         = 3'd7;

   localparam logic        RST_ACTIVE_LOW  = 1'b1;
   localparam logic [15:0] RST_HOLD_TARGET = 16'd1000;
   localparam logic [15:0] RST_MIN_PRESS   = 16'd50;
   localparam logic [15:0] RST_CLICK_GAP   = 16'd300;

   typedef struct packed {
      logic        active_low;
      logic [15:0] hold_target_ms;
      logic [15:0] min_press_ms;
      logic [15:0] click_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  sample_history;
      logic        pressed_flag;
      logic        prev_pressed;
      logic [31:0] press_start_time;
      logic [31:0] last_click_time;
      logic [2:0]  click_total;
      logic        hold_done;
   } state_type;

   typedef struct packed {
      logic        action;
      logic        pin_level;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      event_type event_res;
      logic      is_pressed;
   } result_type;

endpackage

[sv/button_click_hold_detector_unit.sv]
`timescale 1ns / 1ps

// Button debounce with click, double/triple click and hold detection.
// req channel: one item per transfer. tuser carries the action (0 = pin
// sample, 1 = timed step); tdata carries pin_level and a wrapping 32-bit
// millisecond time. Samples feed an 8-deep history; eight equal samples set
// or clear the debounced pressed flag. Steps detect press/release edges,
// fire one hold event per press, count clicks and report them after a gap.
// rsp channel: exactly one result per item, in order: event code and the
// debounced pressed flag after that item.
// A req transfer goes to the input register; the step logic then writes the
// state and the result register together. Throughput is one item per cycle
// when not stalled; the state loop closes through the single step stage, so
// back-to-back items see each other's updates.
// When rsp_tready is low, the result register holds and the input register
// keeps one more item; req_tready drops only when both are full.
// Reset (synchronous) clears all state, empties both registers and loads the
// register defaults: active-low pin, hold 1000 ms, min press 50 ms, gap 300 ms.
// csr writes take effect at the clock edge where csr_we is high; write them
// only while no item is in flight.
module button_click_hold_detector_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [0] pin_level, [32:1] now_ms, rest zero
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] event_res, [3] is_pressed, rest zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bchd_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   item_type   item_ff;
   logic       item_vld_ff;
   result_type res_in;
   result_type res_ff;
   logic       res_vld_ff;
   logic       advance;

   assign advance    = !res_vld_ff || rsp_tready;
   assign req_tready = !item_vld_ff || advance;

   bchd_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low     <= RST_ACTIVE_LOW;
         cfg_ff.hold_target_ms <= RST_HOLD_TARGET;
         cfg_ff.min_press_ms   <= RST_MIN_PRESS;
         cfg_ff.click_gap_ms   <= RST_CLICK_GAP;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_LOW:  cfg_ff.active_low     <= csr_wdata[0];
            CSR_HOLD_TARGET: cfg_ff.hold_target_ms <= csr_wdata;
            CSR_MIN_PRESS:   cfg_ff.min_press_ms   <= csr_wdata;
            CSR_CLICK_GAP:   cfg_ff.click_gap_ms   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= '0;
         item_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            item_vld_ff <= req_tvalid;
         end
         if (advance) begin
            res_vld_ff <= item_vld_ff;
         end
         if (item_vld_ff && advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         item_ff.action    <= req_tuser;
         item_ff.pin_level <= req_tdata[0];
         item_ff.now_ms    <= req_tdata[32:1];
      end
      if (item_vld_ff && advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = res_vld_ff;
   assign rsp_tdata  = {4'd0, res_ff.is_pressed, res_ff.event_res};

endmodule

[sv/bchd_step.sv]
`timescale 1ns / 1ps

// Next-state and result logic for one item: debounce on samples, click/hold on steps.
module bchd_step (
   input  bchd_pkg::cfg_type    cfg,
   input  bchd_pkg::state_type  cur,
   input  bchd_pkg::item_type   item,
   output bchd_pkg::state_type  nxt,
   output bchd_pkg::result_type res
);
   import bchd_pkg::*;

   logic        raw;
   logic [7:0]  hist;
   logic [31:0] start_t;
   logic        hold_d;
   logic [2:0]  clicks;
   logic [31:0] last_t;
   logic [31:0] press_len;
   logic [31:0] gap_len;
   logic        press_edge;
   event_type   ev;

   always_comb begin
      nxt = cur;
      ev  = EV_NONE;

      raw  = cfg.active_low ? ~item.pin_level : item.pin_level;
      hist = {cur.sample_history[6:0], raw};

      press_edge = cur.pressed_flag && !cur.prev_pressed;
      start_t    = press_edge ? item.now_ms : cur.press_start_time;
      hold_d     = press_edge ? 1'b0 : cur.hold_done;
      clicks     = cur.click_total;
      last_t     = cur.last_click_time;
      press_len  = item.now_ms - start_t;

      if (cur.pressed_flag && !hold_d && press_len >= {16'd0, cfg.hold_target_ms}) begin
         ev     = EV_HOLD;
         hold_d = 1'b1;
         clicks = '0;
      end

      if (!cur.pressed_flag && cur.prev_pressed && !hold_d &&
          press_len >= {16'd0, cfg.min_press_ms}) begin
         if (clicks != CLICK_MAX) begin
            clicks = clicks + 3'd1;
         end
         last_t = item.now_ms;
      end

      gap_len = item.now_ms - last_t;
      if (!cur.pressed_flag && clicks != 3'd0 && gap_len >= {16'd0, cfg.click_gap_ms}) begin
         case (clicks)
            3'd1:    ev = EV_SINGLE;
            3'd2:    ev = EV_DOUBLE;
            3'd3:    ev = EV_TRIPLE;
            default: ev = EV_NONE;
         endcase
         clicks = '0;
      end

      if (item.action == ACTION_SAMPLE) begin
         nxt.sample_history = hist;
         if (hist == HIST_ALL_PRESSED) begin
            nxt.pressed_flag = 1'b1;
         end else if (hist == HIST_ALL_RELEASED) begin
            nxt.pressed_flag = 1'b0;
         end
         ev = EV_NONE;
      end else begin
         nxt.press_start_time = start_t;
         nxt.hold_done        = hold_d;
         nxt.click_total      = clicks;
         nxt.last_click_time  = last_t;
         nxt.prev_pressed     = cur.pressed_flag;
      end

      res.event_res  = ev;
      res.is_pressed = nxt.pressed_flag;
   end

endmodule

[sv/bchd_checker.sv]
`timescale 1ns / 1ps

module bchd_assert_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   import bchd_pkg::*;

   // a result held back by the receiver stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= EV_HOLD)
      else $error("rsp event code out of range");

   // hold fires only while pressed, click reports only once released
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == EV_HOLD |-> rsp_tdata[3])
      else $error("hold event without pressed flag");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == EV_SINGLE || rsp_tdata[2:0] == EV_DOUBLE ||
                     rsp_tdata[2:0] == EV_TRIPLE) |-> !rsp_tdata[3])
      else $error("click event while pressed");

endmodule

bind button_click_hold_detector_unit bchd_assert_checker u_bchd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[verif/bchd_checker.sv]
`timescale 1ns / 1ps

module bchd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // [0] pin_level, [32:1] now_ms
   input  logic        req_tuser,   // [0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [2:0] event_res, [3] is_pressed
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          error_count,
   output int          outstanding,
   output int          click_events,
   output int          hold_events
);
   import bchd_pkg::*;

   cfg_type    btn_cfg;
   state_type  btn_state;
   result_type pending_results[$];

   initial begin
      error_count  = 0;
      outstanding  = 0;
      click_events = 0;
      hold_events  = 0;
   end

   // Advances the button model by one item and returns the result it gives.
   function automatic result_type predict_button(input item_type it);
      result_type  res;
      logic        raw;
      logic [31:0] since_press;
      logic [31:0] since_click;
      res.event_res = EV_NONE;
      if (it.action == ACTION_SAMPLE) begin
         raw = btn_cfg.active_low ? ~it.pin_level : it.pin_level;
         btn_state.sample_history = {btn_state.sample_history[6:0], raw};
         if (btn_state.sample_history == HIST_ALL_PRESSED)
            btn_state.pressed_flag = 1'b1;
         else if (btn_state.sample_history == HIST_ALL_RELEASED)
            btn_state.pressed_flag = 1'b0;
      end else begin
         if (btn_state.pressed_flag && !btn_state.prev_pressed) begin
            btn_state.press_start_time = it.now_ms;
            btn_state.hold_done        = 1'b0;
         end
         since_press = it.now_ms - btn_state.press_start_time;
         if (btn_state.pressed_flag && !btn_state.hold_done &&
             since_press >= {16'd0, btn_cfg.hold_target_ms}) begin
            res.event_res         = EV_HOLD;
            btn_state.hold_done   = 1'b1;
            btn_state.click_total = '0;
         end
         if (!btn_state.pressed_flag && btn_state.prev_pressed && !btn_state.hold_done &&
             since_press >= {16'd0, btn_cfg.min_press_ms}) begin
            if (btn_state.click_total != CLICK_MAX)
               btn_state.click_total = btn_state.click_total + 3'd1;
            btn_state.last_click_time = it.now_ms;
         end
         // gap measured against the click time as updated just above
         since_click = it.now_ms - btn_state.last_click_time;
         if (!btn_state.pressed_flag && btn_state.click_total != 0 &&
             since_click >= {16'd0, btn_cfg.click_gap_ms}) begin
            case (btn_state.click_total)
               3'd1:    res.event_res = EV_SINGLE;
               3'd2:    res.event_res = EV_DOUBLE;
               3'd3:    res.event_res = EV_TRIPLE;
               default: res.event_res = EV_NONE;
            endcase
            btn_state.click_total = '0;
         end
         btn_state.prev_pressed = btn_state.pressed_flag;
      end
      res.is_pressed = btn_state.pressed_flag;
      return res;
   endfunction

   always @(posedge clock) begin
      item_type   in_item;
      result_type want;
      logic [2:0] got_event;
      logic       got_pressed;
      if (reset) begin
         btn_cfg.active_low     = RST_ACTIVE_LOW;
         btn_cfg.hold_target_ms = RST_HOLD_TARGET;
         btn_cfg.min_press_ms   = RST_MIN_PRESS;
         btn_cfg.click_gap_ms   = RST_CLICK_GAP;
         btn_state              = '0;
         pending_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ACTIVE_LOW:  btn_cfg.active_low     = csr_wdata[0];
               CSR_HOLD_TARGET: btn_cfg.hold_target_ms = csr_wdata;
               CSR_MIN_PRESS:   btn_cfg.min_press_ms   = csr_wdata;
               CSR_CLICK_GAP:   btn_cfg.click_gap_ms   = csr_wdata;
               default: ;
            endcase
         end
         // results first, so a transfer on this edge never pairs with this edge's item
         if (rsp_tvalid && rsp_tready) begin
            got_event   = rsp_tdata[2:0];
            got_pressed = rsp_tdata[3];
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result: expected none, %s %0d pressed %0b",
                        $time, "actual event", got_event, got_pressed);
            end else begin
               want = pending_results.pop_front();
               if (got_event != want.event_res || got_pressed != want.is_pressed) begin
                  error_count++;
                  $display("%0t: result mismatch: expected event %0d pressed %0b, %s",
                           $time, want.event_res, want.is_pressed, "actual");
                  $display("%0t:    actual event %0d pressed %0b",
                           $time, got_event, got_pressed);
               end
               if (want.event_res == EV_HOLD)
                  hold_events++;
               else if (want.event_res != EV_NONE)
                  click_events++;
            end
         end
         if (req_tvalid && req_tready) begin
            in_item.action    = req_tuser;
            in_item.pin_level = req_tdata[0];
            in_item.now_ms    = req_tdata[32:1];
            pending_results.push_back(predict_button(in_item));
         end
      end
      outstanding = pending_results.size();
   end

endmodule

[verif/button_click_hold_detector_unit_tb.sv]
`timescale 1ns / 1ps

module button_click_hold_detector_unit_tb;
   import bchd_pkg::*;

   localparam int PHASE_ITEMS = 250;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tuser  = ACTION_SAMPLE;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [7:0]  rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_ACTIVE_LOW;
   logic [15:0] csr_wdata  = '0;

   int error_count;
   int outstanding;
   int click_events;
   int hold_events;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   int settings_used = 0;

   // tb copy of the current register values, used to shape gestures
   logic        active_low_now = RST_ACTIVE_LOW;
   logic [15:0] hold_now       = RST_HOLD_TARGET;
   logic [15:0] min_now        = RST_MIN_PRESS;
   logic [15:0] gap_now        = RST_CLICK_GAP;
   logic [31:0] clock_ms       = '0;

   always #5 clock = ~clock;

   button_click_hold_detector_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bchd_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .outstanding  (outstanding),
      .click_events (click_events),
      .hold_events  (hold_events)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // One transfer on the req channel, with random idle cycles ahead of it.
   task automatic push_item(input logic act, input logic pin, input logic [31:0] t);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct && gap < 20)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, t, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic al, input logic [15:0] hold,
                                 input logic [15:0] min_press, input logic [15:0] gap);
      logic [14:0] junk;
      junk = 15'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_ACTIVE_LOW;
      csr_wdata <= {junk, al};   // upper bits must be dropped
      @(posedge clock);
      csr_index <= CSR_HOLD_TARGET;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= CSR_MIN_PRESS;
      csr_wdata <= min_press;
      @(posedge clock);
      csr_index <= CSR_CLICK_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      csr_we <= 1'b0;
      active_low_now = al;
      hold_now       = hold;
      min_now        = min_press;
      gap_now        = gap;
      settings_used++;
   endtask

   // Durations clustered around a threshold, plus a few tiny and wrapping ones.
   function automatic logic [31:0] pick_span(input logic [15:0] th);
      logic [31:0] base;
      base = {16'd0, th};
      case ($urandom_range(0, 5))
         0:       return base - 32'd1;
         1:       return base;
         2:       return base + 32'd1;
         3:       return $urandom_range(0, base);
         4:       return base + $urandom_range(0, 500);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   // Some bounce, then a clean run long enough to flip the debounced flag.
   task automatic drive_level(input logic pressed);
      int   n;
      logic pin_on;
      pin_on = ~active_low_now;
      n = $urandom_range(0, 4);
      repeat (n) push_item(ACTION_SAMPLE, 1'($urandom_range(0, 1)), $urandom);
      n = 8 + $urandom_range(0, 3);
      repeat (n) push_item(ACTION_SAMPLE, pressed ? pin_on : ~pin_on, $urandom);
   endtask

   task automatic run_gesture();
      int          clicks;
      logic [31:0] held;
      if ($urandom_range(0, 3) == 0)
         clock_ms = $urandom;
      clicks = ($urandom_range(0, 6) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
      for (int c = 0; c < clicks; c++) begin
         drive_level(1'b1);
         push_item(ACTION_STEP, 1'($urandom_range(0, 1)), clock_ms);
         held = ($urandom_range(0, 3) == 0) ? pick_span(hold_now) : pick_span(min_now);
         if ($urandom_range(0, 2) == 0)
            push_item(ACTION_STEP, 1'($urandom_range(0, 1)), clock_ms + pick_span(hold_now));
         drive_level(1'b0);
         clock_ms += held;
         push_item(ACTION_STEP, 1'($urandom_range(0, 1)), clock_ms);
         // a step inside the quiet time may or may not close the sequence
         if (c != clicks - 1 && $urandom_range(0, 1) == 0) begin
            if (gap_now != 0 && $urandom_range(0, 3) != 0)
               clock_ms += $urandom_range(0, gap_now - 1);
            else
               clock_ms += pick_span(gap_now);
            push_item(ACTION_STEP, 1'($urandom_range(0, 1)), clock_ms);
         end
      end
      repeat ($urandom_range(1, 3)) begin
         clock_ms += pick_span(gap_now);
         push_item(ACTION_STEP, 1'($urandom_range(0, 1)), clock_ms);
      end
   endtask

   task automatic scramble_items();
      repeat ($urandom_range(3, 12))
         push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct);
      int first;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) begin
         if ($urandom_range(0, 4) == 0)
            scramble_items();
         else
            run_gesture();
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: active-low pin, hold 1000 ms; hold fires across the time wrap
      push_item(ACTION_STEP, 1'b1, 32'd0);
      repeat (8) push_item(ACTION_SAMPLE, 1'b0, 32'hFFFF_FFFF);
      push_item(ACTION_STEP, 1'b0, 32'hFFFF_FFF0);
      push_item(ACTION_STEP, 1'b1, 32'hFFFF_FFF0 + 32'd999);
      push_item(ACTION_STEP, 1'b0, 32'hFFFF_FFF0 + 32'd1000);
      push_item(ACTION_STEP, 1'b1, 32'h0000_1000);
      repeat (7) push_item(ACTION_SAMPLE, 1'b1, 32'd0);
      push_item(ACTION_SAMPLE, 1'b1, 32'hFFFF_FFFF);
      // release after a hold counts no click
      push_item(ACTION_STEP, 1'b0, 32'hFFFF_FFFF);
      drain();

      apply_settings(1'b0, 16'd200, 16'd20, 16'd100);
      random_phase(0, 0);
      apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(69, 0);
      apply_settings(1'b0, 16'd0, 16'd0, 16'd0);
      random_phase(0, 69);
      apply_settings(1'b1, 16'($urandom_range(0, 400)), 16'($urandom_range(0, 100)),
                     16'($urandom_range(0, 400)));
      random_phase(23, 23);
      apply_settings(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                     16'($urandom));
      random_phase(0, 0);

      repeat (10) @(posedge clock);
      $display("Ran %0d items under %0d register settings; %0d click and %0d hold events",
               items_sent, settings_used, click_events, hold_events);
      if (error_count == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
